// ===== hw/rtl/fslot_pkg.sv =====
`timescale 1ns / 1ps

package fslot_pkg;

    localparam int SLOT_COUNT_DEFAULT = 256;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_POOL_EMPTY  = 2'd1,
        STATUS_NOT_IN_USE  = 2'd2
    } status_t;

    typedef enum logic {
        KIND_ALLOCATE = 1'b0,
        KIND_RELEASE  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] slot_to_release;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] granted_slot;
        logic [8:0] free_count;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== hw/rtl/fixed_slot_free_list_allocator_top.sv =====
`timescale 1ns / 1ps

// Fixed-slot free-list allocator.
// s_* channel takes requests (allocate, or release of a slot index); m_* channel
// returns one response per request: status, granted slot, free count afterwards.
// Free slot indices live in a LIFO stack memory, in-use marks in a second memory;
// both are synchronous RAMs with a registered read port.
// Each transaction reads the stack memory (allocate) or the mark memory (release)
// on accept, then updates the memories and loads the response register. The next
// request is accepted in the cycle after the response is loaded, so a new request
// is not taken before the last one has completed its read-modify-write.
// Reset empties the response register and restores a full pool: a high-water
// mark tracks how far the stack was ever popped, and entries above it read as
// never used, so no clearing pass is run.
// When the receiver stalls, the response register holds; one more request can be
// read but is not completed until the response register frees up.
module fixed_slot_free_list_allocator_top
    import fslot_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int DW   = $clog2(SLOT_COUNT + 1);
    localparam int CmpW = (DW > 8) ? DW : 8;
    localparam int FW   = (DW > 9) ? DW : 9;
    localparam logic [DW-1:0]   SlotCountD = DW'(SLOT_COUNT);
    localparam logic [CmpW-1:0] SlotCountC = CmpW'(SLOT_COUNT);

    logic [SW-1:0] stack_mem [SLOT_COUNT];
    logic          mark_mem  [SLOT_COUNT];

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] top_reg, top_next;
    logic [DW-1:0] hw_reg, hw_next;
    logic          m_valid_reg, m_valid_next;
    rsp_t          m_data_reg, m_data_next;
    logic [SW-1:0] stack_rd_reg;
    logic          mark_rd_reg;

    logic          accept;
    logic          exec_go;
    logic          stack_re, mark_re;
    logic          stack_we, mark_we;
    logic [SW-1:0] stack_waddr, mark_addr_w;
    logic [SW-1:0] stack_wdata;
    logic          mark_wdata;
    logic [CmpW-1:0] in_slot_ext, req_slot_ext;
    logic          req_in_range;
    logic [SW-1:0] req_slot_idx;
    logic [SW-1:0] granted;
    logic          slot_in_use;

    // output decode
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        exec_go = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    end

    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_go) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // read side, issued on accept
    assign in_slot_ext = CmpW'(s_data.slot_to_release);
    assign stack_re    = accept && (s_data.kind == KIND_ALLOCATE) && (depth_reg != '0);
    assign mark_re     = accept && (s_data.kind == KIND_RELEASE) && (in_slot_ext < SlotCountC);

    // update side
    assign req_slot_ext = CmpW'(req_reg.slot_to_release);
    assign req_in_range = req_slot_ext < SlotCountC;
    assign req_slot_idx = req_slot_ext[SW-1:0];

    // entries at or above the high-water mark were never written and are taken as their own index
    assign granted = (top_reg >= hw_reg) ? top_reg[SW-1:0] : stack_rd_reg;
    // slots at or above the high-water mark were never handed out
    assign slot_in_use = req_in_range && (req_slot_ext < CmpW'(hw_reg)) && mark_rd_reg;

    always_comb begin
        depth_next   = depth_reg;
        top_next     = top_reg;
        hw_next      = hw_reg;
        stack_we     = 1'b0;
        stack_waddr  = top_reg[SW-1:0];
        stack_wdata  = req_slot_idx;
        mark_we      = 1'b0;
        mark_addr_w  = req_slot_idx;
        mark_wdata   = 1'b0;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        if (m_ready) m_valid_next = 1'b0;

        if (exec_go) begin
            m_valid_next = 1'b1;
            if (req_reg.kind == KIND_ALLOCATE) begin
                if (depth_reg == '0) begin
                    m_data_next.status       = STATUS_POOL_EMPTY;
                    m_data_next.granted_slot = '0;
                    m_data_next.free_count   = '0;
                end else begin
                    depth_next  = depth_reg - 1'b1;
                    top_next    = top_reg + 1'b1;
                    if (top_reg == hw_reg) hw_next = hw_reg + 1'b1;
                    mark_we     = 1'b1;
                    mark_addr_w = granted;
                    mark_wdata  = 1'b1;
                    m_data_next.status       = STATUS_OK;
                    m_data_next.granted_slot = 8'(CmpW'(granted));
                    m_data_next.free_count   = 9'(FW'(depth_reg - 1'b1));
                end
            end else begin
                if (!slot_in_use || depth_reg == SlotCountD) begin
                    m_data_next.status       = STATUS_NOT_IN_USE;
                    m_data_next.granted_slot = '0;
                    m_data_next.free_count   = 9'(FW'(depth_reg));
                end else begin
                    depth_next  = depth_reg + 1'b1;
                    top_next    = top_reg - 1'b1;
                    stack_we    = 1'b1;
                    stack_waddr = SW'(top_reg - 1'b1);
                    mark_we     = 1'b1;
                    m_data_next.status       = STATUS_OK;
                    m_data_next.granted_slot = '0;
                    m_data_next.free_count   = 9'(FW'(depth_reg + 1'b1));
                end
            end
        end
    end

    // stack memory
    always_ff @(posedge aclk) begin
        if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
        if (stack_re) stack_rd_reg <= stack_mem[top_reg[SW-1:0]];
    end

    // in-use mark memory
    always_ff @(posedge aclk) begin
        if (mark_we) mark_mem[mark_addr_w] <= mark_wdata;
        if (mark_re) mark_rd_reg <= mark_mem[in_slot_ext[SW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (accept) req_reg <= s_data;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= SlotCountD;
            top_reg     <= '0;
            hw_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            top_reg     <= top_next;
            hw_reg      <= hw_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
